[rtl/assert_macros.svh]
// assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/pcc_pkg.sv]
package pcc_pkg;

  localparam int TGT_W       = 6;
  localparam int TGT_N       = 64;
  localparam int ZCNT_W      = 7;
  localparam int IN_Q_DEPTH  = 2;
  localparam int OUT_Q_DEPTH = 4;
  localparam int IQ_LVL_W    = $clog2(IN_Q_DEPTH) + 1;
  localparam int OQ_LVL_W    = $clog2(OUT_Q_DEPTH) + 1;

  typedef struct packed {
    logic [TGT_W-1:0] target_index;
    logic             is_zero_color;
    logic             last_element;
  } in_word_t;

  typedef struct packed {
    logic [ZCNT_W-1:0] group_zero_count;
    logic              last_result;
  } out_word_t;

  typedef struct packed {
    logic             keep;
    logic             last;
    logic             zero;
    logic [TGT_W-1:0] tgt;
  } q_word_t;

endpackage

[rtl/pcc_fifo.sv]
module pcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   lvl_r;
  logic             do_push;
  logic             do_pop;

  assign full     = lvl_r == (PTR_W+1)'(DEPTH);
  assign empty    = lvl_r == '0;
  assign level    = lvl_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        lvl_r <= lvl_r + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        lvl_r <= lvl_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

[rtl/pcc_front.sv]
module pcc_front #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pcc_pkg::in_word_t  in_word,
  output logic               in_stall,
  output logic               q_push,
  output pcc_pkg::q_word_t   q_word,
  input  logic               q_full
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [pcc_pkg::TGT_W-1:0] mod_lut [pcc_pkg::TGT_N];
  logic [CNT_W-1:0]          f_cnt_r;
  logic                      keep;

  // target index folded into capacity
  for (genvar i = 0; i < pcc_pkg::TGT_N; i++) begin : g_mod
    assign mod_lut[i] = pcc_pkg::TGT_W'(i % MAX_ELEMENTS);
  end

  assign keep     = f_cnt_r < CNT_W'(MAX_ELEMENTS);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_word.keep = keep;
    q_word.last = in_word.last_element;
    q_word.zero = in_word.is_zero_color;
    q_word.tgt  = mod_lut[in_word.target_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_cnt_r <= '0;
    end else if (q_push) begin
      if (in_word.last_element) begin
        f_cnt_r <= '0;
      end else if (keep) begin
        f_cnt_r <= f_cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

[rtl/pcc_back.sv]
module pcc_back #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  pcc_pkg::q_word_t               q_word,
  output logic                           q_pop,
  output logic                           res_push,
  output pcc_pkg::out_word_t             res_word,
  input  logic [pcc_pkg::OQ_LVL_W-1:0]   res_level
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int USE_W = pcc_pkg::OQ_LVL_W + 1;

  typedef enum logic [1:0] {S_LOAD, S_SCAN, S_STEP, S_EMIT} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        wr_cnt_r;
  logic [CNT_W-1:0]        n_r;
  logic [IDX_W-1:0]        k_r;
  logic [IDX_W-1:0]        lead_r;
  logic [CNT_W-1:0]        acc_r;
  logic [MAX_ELEMENTS-1:0] lab_r;

  logic [IDX_W-1:0] tgt_mem [MAX_ELEMENTS];
  logic             col_mem [MAX_ELEMENTS];
  logic [IDX_W-1:0] ldr_mem [MAX_ELEMENTS];
  logic [CNT_W-1:0] cnt_mem [MAX_ELEMENTS];

  logic [IDX_W-1:0] tgt_rd_r;
  logic             col_rd_r;
  logic [IDX_W-1:0] ldr_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic             s1_v_r;
  logic             s1_last_r;
  logic             s2_v_r;
  logic             s2_last_r;

  logic             k_last;
  logic [CNT_W-1:0] acc_sum;
  logic             stop;
  logic [IDX_W-1:0] rd_addr;
  logic             ld_we;
  logic             lw_en;
  logic [IDX_W-1:0] lw_data;
  logic             cw_en;
  logic [USE_W-1:0] used;
  logic             issue;

  assign k_last  = (CNT_W'(k_r) + CNT_W'(1)) == n_r;
  assign acc_sum = acc_r + CNT_W'(col_rd_r);
  assign stop    = (CNT_W'(tgt_rd_r) >= n_r) || lab_r[tgt_rd_r];
  assign rd_addr = (state_r == S_SCAN) ? k_r : tgt_rd_r;
  assign q_pop   = (state_r == S_LOAD) && q_valid;
  assign ld_we   = q_pop && q_word.keep;
  assign lw_en   = ((state_r == S_SCAN) && !lab_r[k_r]) || ((state_r == S_STEP) && !stop);
  assign lw_data = (state_r == S_SCAN) ? k_r : lead_r;
  assign cw_en   = (state_r == S_STEP) && stop;

  // results in flight are counted against free space in the output queue
  assign used  = USE_W'(res_level) + USE_W'(s1_v_r) + USE_W'(s2_v_r);
  assign issue = (state_r == S_EMIT) && (used < USE_W'(pcc_pkg::OUT_Q_DEPTH));

  assign res_push                  = s2_v_r;
  assign res_word.group_zero_count = pcc_pkg::ZCNT_W'(cnt_rd_r);
  assign res_word.last_result      = s2_last_r;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      tgt_mem[wr_cnt_r[IDX_W-1:0]] <= q_word.tgt[IDX_W-1:0];
      col_mem[wr_cnt_r[IDX_W-1:0]] <= q_word.zero;
    end
    tgt_rd_r <= tgt_mem[rd_addr];
    col_rd_r <= col_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      ldr_mem[rd_addr] <= lw_data;
    end
    ldr_rd_r <= ldr_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cnt_mem[lead_r] <= acc_sum;
    end
    cnt_rd_r <= cnt_mem[ldr_rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      wr_cnt_r <= '0;
      lab_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      s1_v_r    <= issue;
      s1_last_r <= k_last;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      unique case (state_r)
        S_LOAD: begin
          if (q_pop) begin
            if (q_word.keep) begin
              wr_cnt_r <= wr_cnt_r + CNT_W'(1);
            end
            if (q_word.last) begin
              n_r     <= wr_cnt_r + CNT_W'(q_word.keep);
              k_r     <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (lab_r[k_r]) begin
            if (k_last) begin
              k_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              k_r <= k_r + IDX_W'(1);
            end
          end else begin
            lab_r[k_r] <= 1'b1;
            lead_r     <= k_r;
            acc_r      <= '0;
            state_r    <= S_STEP;
          end
        end
        S_STEP: begin
          if (stop) begin
            if (k_last) begin
              k_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              k_r     <= k_r + IDX_W'(1);
              state_r <= S_SCAN;
            end
          end else begin
            lab_r[tgt_rd_r] <= 1'b1;
            acc_r           <= acc_sum;
          end
        end
        S_EMIT: begin
          if (issue) begin
            if (k_last) begin
              wr_cnt_r <= '0;
              lab_r    <= '0;
              state_r  <= S_LOAD;
            end else begin
              k_r <= k_r + IDX_W'(1);
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

[rtl/permutation_cycle_color_count.sv]
// loading: one element per cycle through a two-entry queue, stalled while the queue is full
// grouping, after the last element: each index is scanned and each unlabeled one is followed
//   along its cycle, labeling elements, bounded by the single read port of the target store
// results: one per cycle while the output queue has room, via the leader and count stores
// reset: synchronous, active low; clears queues, labels and sequencer, stores keep contents
`include "assert_macros.svh"

module permutation_cycle_color_count #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pcc_pkg::in_word_t   in_word,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pcc_pkg::out_word_t  out_word
);

  pcc_pkg::q_word_t                  iq_in;
  pcc_pkg::q_word_t                  iq_out;
  logic                              iq_push;
  logic                              iq_full;
  logic                              iq_empty;
  logic [pcc_pkg::IQ_LVL_W-1:0]      iq_level;
  logic                              q_pop;
  logic                              res_push;
  pcc_pkg::out_word_t                res_word;
  logic [$bits(pcc_pkg::out_word_t)-1:0] oq_data;
  logic                              oq_full;
  logic                              oq_empty;
  logic                              oq_pop;
  logic [pcc_pkg::OQ_LVL_W-1:0]      oq_level;

  pcc_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .q_push   (iq_push),
    .q_word   (iq_in),
    .q_full   (iq_full)
  );

  pcc_fifo #(
    .WIDTH ($bits(pcc_pkg::q_word_t)),
    .DEPTH (pcc_pkg::IN_Q_DEPTH)
  ) u_in_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (iq_push),
    .push_data (iq_in),
    .pop       (q_pop),
    .pop_data  (iq_out),
    .full      (iq_full),
    .empty     (iq_empty),
    .level     (iq_level)
  );

  pcc_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!iq_empty),
    .q_word    (iq_out),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_level (oq_level)
  );

  pcc_fifo #(
    .WIDTH ($bits(pcc_pkg::out_word_t)),
    .DEPTH (pcc_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_word),
    .pop       (oq_pop),
    .pop_data  (oq_data),
    .full      (oq_full),
    .empty     (oq_empty),
    .level     (oq_level)
  );

  assign out_valid = !oq_empty;
  assign oq_pop    = out_valid && !out_stall;
  assign out_word  = pcc_pkg::out_word_t'(oq_data);

  `PCC_ASSERT_IMPL(a_no_result_overflow, clk, rst_n, res_push, !oq_full || oq_pop)
  `PCC_ASSERT_IMPL(a_pop_needs_word, clk, rst_n, q_pop, !iq_empty)
  `PCC_ASSERT_NEXT(a_push_lands, clk, rst_n, iq_push && iq_empty, !iq_empty)
  `PCC_ASSERT_IMPL(a_in_q_level, clk, rst_n, iq_empty, iq_level == '0)

endmodule
